/* hdl/mwr_pkg.sv */
// Package for the Microwire EEPROM word reader: sequencer phases, sizes and command constants.
package mwr_pkg;

    // Serial frame sizes
    localparam int COMMAND_BITS = 9;
    localparam int ADDRESS_BITS = 6;
    localparam int DATA_BITS    = 16;

    // Field widths fixed by the transaction layout
    localparam int ADDR_W  = 6;
    localparam int COUNT_W = 7;
    localparam int WORD_W  = 16;
    localparam int SHIFT_W = 16;
    localparam int BITCNT_W = 5;

    // Stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Start bit plus read opcode, sent ahead of the address
    localparam logic [31:0] READ_PREFIX = 32'd6;
    localparam logic [31:0] ADDR_MASK   = (32'd1 << ADDRESS_BITS) - 32'd1;
    localparam logic [31:0] CMD_MASK    = ((32'd1 << COMMAND_BITS) - 32'd1) & 32'h0000_FFFF;

    // Request kinds carried in s_axis_tuser
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_CS_LOW  = 3'd1,
        PH_CS_HIGH = 3'd2,
        PH_CMD     = 3'd3,
        PH_READ    = 3'd4
    } phase_t;

endpackage

/* hdl/microwire_eeprom_word_reader_core.sv */
// Microwire EEPROM word reader: one pin write per tick transaction, result register on the output.
//
//  channel   | dir | handshake            | payload
//  ----------+-----+----------------------+-------------------------------------------------
//  s_axis    | in  | tvalid / tready      | tuser: req_type; tdata: start_address, word_count,
//            |     |                      |        data_out_pin
//  m_axis    | out | tvalid / tready      | tuser: word_valid; tlast: last_word; tdata: pins,
//            |     |                      |        busy_res, word_data
//  cfg       | in  | wr_en (no wait)      | wr_data: swap_bytes
//
// Every transaction updates the sequencer state and the result register at the same edge,
// so one transaction per clock is taken while the output is free or drained.
// A 64-address word costs 2 + 3*COMMAND_BITS + 2*DATA_BITS tick transactions (61 here).
// rst_n clears the sequencer, the pin levels, the output valid and swap_bytes.
// When m_axis stalls with a result held, s_axis_tready drops until that result is taken.
module microwire_eeprom_word_reader_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // config
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,    // swap_bytes
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mwr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [5:0] start_address,
                                                             // [12:6] word_count,
                                                             // [13] data_out_pin, [15:14] zero
    input  logic                             s_axis_tuser,   // [0] req_type
    // output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mwr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // [0] chip_select,
                                                             // [1] serial_clock,
                                                             // [2] serial_data, [3] busy_res,
                                                             // [19:4] word_data, [23:20] zero
    output logic                             m_axis_tuser,   // [0] word_valid
    output logic                             m_axis_tlast    // last_word
);
    import mwr_pkg::*;

    // Sequencer state
    phase_t                phase_reg,   phase_next;
    logic [1:0]            sub_reg,     sub_next;
    logic [BITCNT_W-1:0]   bitcnt_reg,  bitcnt_next;
    logic [SHIFT_W-1:0]    cmd_reg,     cmd_next;
    logic [WORD_W-1:0]     acc_reg,     acc_next;
    logic [ADDR_W-1:0]     addr_reg,    addr_next;
    logic [COUNT_W-1:0]    left_reg,    left_next;
    logic                  cs_reg,      cs_next;
    logic                  sclk_reg,    sclk_next;
    logic                  sdi_reg,     sdi_next;
    logic                  swap_reg;

    // Output register
    logic                  out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_user_reg,  out_user_next;
    logic                  out_last_reg,  out_last_next;

    // Unpacked input fields
    logic                  req_type;
    logic [ADDR_W-1:0]     start_address;
    logic [COUNT_W-1:0]    word_count;
    logic                  data_out_pin;
    logic                  in_acc;

    // Working values
    logic [31:0]           cmd_word;
    logic [BITCNT_W-1:0]   bitcnt_inc;
    logic [WORD_W-1:0]     acc_shift;
    logic [WORD_W-1:0]     word_out;
    logic                  word_done;
    logic                  cmd_done;

    assign req_type      = s_axis_tuser;
    assign start_address = s_axis_tdata[5:0];
    assign word_count    = s_axis_tdata[12:6];
    assign data_out_pin  = s_axis_tdata[13];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Read command for the current address, start bit first
    assign cmd_word   = ((READ_PREFIX << ADDRESS_BITS) | (32'(addr_reg) & ADDR_MASK)) & CMD_MASK;
    assign bitcnt_inc = bitcnt_reg + BITCNT_W'(1);
    assign acc_shift  = {acc_reg[WORD_W-2:0], data_out_pin};
    assign cmd_done   = 32'(bitcnt_inc) >= 32'(COMMAND_BITS);
    assign word_done  = 32'(bitcnt_inc) >= 32'(DATA_BITS);
    assign word_out   = swap_reg ? {acc_shift[7:0], acc_shift[15:8]} : acc_shift;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (req_type == REQ_START) begin
            if (phase_reg == PH_IDLE && word_count != '0)
            begin
                phase_next = PH_CS_LOW;
            end
        end else begin
            case (phase_reg)
                PH_IDLE:    phase_next = PH_IDLE;
                PH_CS_LOW:  phase_next = PH_CS_HIGH;
                PH_CS_HIGH: phase_next = PH_CMD;
                PH_CMD:
                begin
                    if (sub_reg == 2'd2 && cmd_done)
                    begin
                        phase_next = PH_READ;
                    end
                end
                PH_READ:
                begin
                    if (sub_reg != 2'd0 && word_done)
                    begin
                        phase_next = (left_reg == COUNT_W'(1)) ? PH_IDLE : PH_CS_LOW;
                    end
                end
                default:    phase_next = PH_IDLE;
            endcase
        end
    end

    // Datapath, pins and result
    always_comb
    begin
        sub_next      = sub_reg;
        bitcnt_next   = bitcnt_reg;
        cmd_next      = cmd_reg;
        acc_next      = acc_reg;
        addr_next     = addr_reg;
        left_next     = left_reg;
        cs_next       = cs_reg;
        sclk_next     = sclk_reg;
        sdi_next      = sdi_reg;
        out_user_next = 1'b0;
        out_last_next = 1'b0;
        out_data_next = '0;
        if (req_type == REQ_START) begin
            if (phase_reg == PH_IDLE && word_count != '0)
            begin
                addr_next   = start_address;
                left_next   = word_count;
                sub_next    = '0;
                bitcnt_next = '0;
            end
        end else begin
            case (phase_reg)
                PH_CS_LOW:
                begin
                    cs_next   = 1'b0;
                    sclk_next = 1'b0;
                    sdi_next  = 1'b0;
                end
                PH_CS_HIGH:
                begin
                    cs_next     = 1'b1;
                    sclk_next   = 1'b0;
                    sdi_next    = 1'b0;
                    cmd_next    = cmd_word[SHIFT_W-1:0];
                    bitcnt_next = '0;
                    sub_next    = '0;
                end
                PH_CMD:
                begin
                    case (sub_reg)
                        2'd0:
                        begin
                            cs_next   = 1'b1;
                            sclk_next = 1'b0;
                            sdi_next  = cmd_reg[COMMAND_BITS-1];
                            sub_next  = 2'd1;
                        end
                        2'd1:
                        begin
                            sclk_next = 1'b0;
                            sub_next  = 2'd2;
                        end
                        default:
                        begin
                            sclk_next   = 1'b1;
                            cmd_next    = {cmd_reg[SHIFT_W-2:0], 1'b0};
                            bitcnt_next = bitcnt_inc;
                            sub_next    = 2'd0;
                            if (cmd_done)
                            begin
                                bitcnt_next = '0;
                                acc_next    = '0;
                            end
                        end
                    endcase
                end
                PH_READ:
                begin
                    if (sub_reg == 2'd0)
                    begin
                        sclk_next = 1'b0;
                        sub_next  = 2'd1;
                    end else begin
                        sclk_next   = 1'b1;
                        acc_next    = acc_shift;
                        bitcnt_next = bitcnt_inc;
                        sub_next    = 2'd0;
                        if (word_done)
                        begin
                            out_user_next = 1'b1;
                            out_last_next = (left_reg == COUNT_W'(1));
                            out_data_next[19:4] = word_out;
                            left_next   = left_reg - COUNT_W'(1);
                            addr_next   = addr_reg + ADDR_W'(1);
                            bitcnt_next = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        out_data_next[0] = cs_next;
        out_data_next[1] = sclk_next;
        out_data_next[2] = sdi_next;
        out_data_next[3] = (phase_next != PH_IDLE);
    end

    // Sequencer and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            sub_reg    <= '0;
            bitcnt_reg <= '0;
            cmd_reg    <= '0;
            acc_reg    <= '0;
            addr_reg   <= '0;
            left_reg   <= '0;
            cs_reg     <= 1'b0;
            sclk_reg   <= 1'b0;
            sdi_reg    <= 1'b0;
            swap_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en)
            begin
                swap_reg <= cfg_wr_data;
            end
            if (in_acc)
            begin
                phase_reg  <= phase_next;
                sub_reg    <= sub_next;
                bitcnt_reg <= bitcnt_next;
                cmd_reg    <= cmd_next;
                acc_reg    <= acc_next;
                addr_reg   <= addr_next;
                left_reg   <= left_next;
                cs_reg     <= cs_next;
                sclk_reg   <= sclk_next;
                sdi_reg    <= sdi_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end else if (in_acc) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // Checks
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser && !m_axis_tdata[3])
        else $error("last word reported while run still busy");

    a_word_on_clock_high: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[0] && m_axis_tdata[1])
        else $error("word completed without chip select and clock high");

    a_cmd_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CMD |-> 32'(bitcnt_reg) < 32'(COMMAND_BITS))
        else $error("command bit counter out of range");

    a_idle_no_words: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> sub_reg == 2'd0)
        else $error("sub-step not cleared on return to idle");

endmodule
